// ===== src/mbt_pkg.sv =====
// ----------------------------------------------------------------------------
// mbt_pkg: shared types and lexer tables for the markup byte tokenizer
// Payload structs, lexer state and character class codes, and the
// transition function of the eleven-state lexer.
// ----------------------------------------------------------------------------
package mbt_pkg;

  localparam int unsigned POSITION_WIDTH_DEF = 16;
  localparam int unsigned POS_OUT_W          = 16;

  localparam logic [7:0] CHAR_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CHAR_BANG  = 8'h21;  // '!'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_NL    = 8'h0A;  // newline

  typedef enum logic [1:0] {
    ROLE_NONE    = 2'd0,
    ROLE_TEXT    = 2'd1,
    ROLE_TAG     = 2'd2,
    ROLE_COMMENT = 2'd3
  } role_t;

  typedef enum logic [3:0] {
    ST_TEXT      = 4'd0,
    ST_LT        = 4'd1,   // after '<'
    ST_TAG       = 4'd2,   // tag name
    ST_SLASH     = 4'd3,   // after "</"
    ST_TEND      = 4'd4,   // token end
    ST_BANG      = 4'd5,   // after "<!"
    ST_DASH2     = 4'd6,   // dash seen inside comment
    ST_CEND      = 4'd7,   // "--" seen, waiting for '>'
    ST_DASH1     = 4'd8,   // "<!-" seen
    ST_COMMENT   = 4'd9,   // comment body
    ST_TAG_OPEN  = 4'd10   // first tag name byte after '<'
  } lex_state_t;

  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_BANG  = 3'd1,
    CLS_SLASH = 3'd2,
    CLS_GT    = 3'd3,
    CLS_LT    = 3'd4,
    CLS_DASH  = 3'd5
  } char_cls_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0]           byte_out;
    logic [1:0]           role;
    logic                 token_end;
    logic                 closing_tag;
    logic [POS_OUT_W-1:0] line_number;
    logic [POS_OUT_W-1:0] column_number;
  } out_t;

  // Per-state character class: each state only looks at a few characters.
  function automatic char_cls_t char_class(lex_state_t st, logic [7:0] c);
    char_cls_t cls;
    cls = CLS_OTHER;
    unique case (st)
      ST_LT: begin
        if (c == CHAR_BANG) cls = CLS_BANG;
        else if (c == CHAR_SLASH) cls = CLS_SLASH;
      end
      ST_TAG, ST_TAG_OPEN: begin
        if (c == CHAR_GT) cls = CLS_GT;
        else if (c == CHAR_LT) cls = CLS_LT;
      end
      ST_SLASH, ST_TEND: cls = CLS_OTHER;
      ST_BANG, ST_DASH2, ST_DASH1, ST_COMMENT: begin
        if (c == CHAR_DASH) cls = CLS_DASH;
      end
      ST_CEND: begin
        if (c == CHAR_GT) cls = CLS_GT;
      end
      default: begin
        if (c == CHAR_LT) cls = CLS_LT;
      end
    endcase
    return cls;
  endfunction

  // Transition table; unlisted pairs fall back to text.
  function automatic lex_state_t next_lex(char_cls_t cls, lex_state_t st);
    lex_state_t nxt;
    nxt = ST_TEXT;
    unique case (st)
      ST_TEXT:     if (cls == CLS_LT) nxt = ST_LT;
      ST_LT: begin
        case (cls)
          CLS_OTHER: nxt = ST_TAG_OPEN;
          CLS_BANG:  nxt = ST_BANG;
          CLS_SLASH: nxt = ST_SLASH;
          default:   nxt = ST_TEXT;
        endcase
      end
      ST_TAG, ST_TAG_OPEN: begin
        case (cls)
          CLS_OTHER: nxt = ST_TAG;
          CLS_GT:    nxt = ST_TEND;
          CLS_LT:    nxt = ST_LT;
          default:   nxt = ST_TEXT;
        endcase
      end
      ST_SLASH:    if (cls == CLS_OTHER) nxt = ST_TAG;
      ST_TEND:     nxt = ST_TEXT;
      ST_BANG: begin
        if (cls == CLS_OTHER) nxt = ST_TAG;
        else if (cls == CLS_DASH) nxt = ST_DASH1;
      end
      ST_DASH2: begin
        if (cls == CLS_OTHER) nxt = ST_COMMENT;
        else if (cls == CLS_DASH) nxt = ST_CEND;
      end
      ST_CEND: begin
        if (cls == CLS_OTHER) nxt = ST_COMMENT;
        else if (cls == CLS_GT) nxt = ST_TEND;
      end
      ST_DASH1: begin
        if (cls == CLS_OTHER) nxt = ST_TAG;
        else if (cls == CLS_DASH) nxt = ST_COMMENT;
      end
      ST_COMMENT: begin
        if (cls == CLS_OTHER) nxt = ST_COMMENT;
        else if (cls == CLS_DASH) nxt = ST_DASH2;
      end
      default:     nxt = ST_TEXT;
    endcase
    return nxt;
  endfunction

endpackage

// ===== src/markup_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// markup_byte_tokenizer: one-byte-per-clock markup lexer
// Classifies each byte of a filtered markup stream, marks token ends and
// tracks saturating line and column positions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries one byte and a last flag
//   per request. Output channel out_valid/out_ready/out_data returns exactly
//   one result per request: the byte echoed, its role, token end, closing
//   tag flag and the line/column position after that byte.
//   The result is registered: a request accepted at one edge shows on out_data
//   from the next cycle. While the receiver keeps up, one byte is taken per
//   clock; the lexer state, close flag and position counters update in the
//   same cycle the byte is accepted, so the next byte is taken right away.
//   The result register is the only buffer: when the receiver stalls, the
//   result holds and in_ready drops until it is taken (in_ready follows
//   out_ready combinationally while a result is pending).
//   A request with last set forces a token end and returns all lexer state
//   and counters to their reset values for the next stream.
//   Reset (rst_n low, synchronous) clears the lexer to the text state,
//   zeroes the counters and empties the result register.
// ----------------------------------------------------------------------------
module markup_byte_tokenizer
  import mbt_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};
  localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

  lex_state_t                lex_r, lex_nxt;
  lex_state_t                lex_raw;   // table result before token end folds to text
  logic                      close_r, close_nxt;
  logic                      cact_r, cact_nxt;
  logic [POSITION_WIDTH-1:0] line_r, line_nxt;
  logic [POSITION_WIDTH-1:0] col_r, col_nxt;
  logic                      out_valid_r;
  out_t                      out_r, out_nxt;
  logic [POS_OUT_W-1:0]      line_out, col_out;
  logic                      in_fire;
  logic                      is_nl;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign is_nl     = (in_data.byte_in == CHAR_NL);

  // Next state: lexer, flags and counters.
  always_comb begin
    lex_raw   = next_lex(char_class(lex_r, in_data.byte_in), lex_r);
    lex_nxt   = (lex_raw == ST_TEND) ? ST_TEXT : lex_raw;
    close_nxt = close_r;
    if (lex_r == ST_SLASH) close_nxt = 1'b1;
    if (lex_r == ST_TAG_OPEN) close_nxt = 1'b0;
    cact_nxt = cact_r;
    if (lex_r == ST_COMMENT) cact_nxt = (lex_raw == ST_COMMENT);
    line_nxt = line_r;
    col_nxt  = col_r;
    if (is_nl) begin
      if (line_r != POS_MAX) line_nxt = line_r + POS_ONE;
      col_nxt = '0;
    end else if (col_r != POS_MAX) begin
      col_nxt = col_r + POS_ONE;
    end
  end

  generate
    if (POSITION_WIDTH >= POS_OUT_W) begin : g_pos_trunc
      assign line_out = line_nxt[POS_OUT_W-1:0];
      assign col_out  = col_nxt[POS_OUT_W-1:0];
    end else begin : g_pos_ext
      assign line_out = {{(POS_OUT_W-POSITION_WIDTH){1'b0}}, line_nxt};
      assign col_out  = {{(POS_OUT_W-POSITION_WIDTH){1'b0}}, col_nxt};
    end
  endgenerate

  // Outputs: result fields for the byte being accepted.
  always_comb begin
    out_nxt.byte_out      = in_data.byte_in;
    out_nxt.line_number   = line_out;
    out_nxt.column_number = col_out;
    if (lex_raw == ST_TAG || lex_raw == ST_TAG_OPEN) out_nxt.role = ROLE_TAG;
    else if (lex_raw == ST_TEXT && lex_r == ST_TEXT) out_nxt.role = ROLE_TEXT;
    else if (cact_nxt) out_nxt.role = ROLE_COMMENT;
    else out_nxt.role = ROLE_NONE;
    if (lex_raw == ST_TEND || in_data.last) begin
      out_nxt.token_end   = 1'b1;
      out_nxt.closing_tag = close_nxt;
    end else begin
      out_nxt.token_end   = 1'b0;
      out_nxt.closing_tag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_r       <= ST_TEXT;
      close_r     <= 1'b0;
      cact_r      <= 1'b0;
      line_r      <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (in_data.last) begin
          // drop all stream state so the next byte starts fresh
          lex_r   <= ST_TEXT;
          close_r <= 1'b0;
          cact_r  <= 1'b0;
          line_r  <= '0;
          col_r   <= '0;
        end else begin
          lex_r   <= lex_nxt;
          close_r <= close_nxt;
          cact_r  <= cact_nxt;
          line_r  <= line_nxt;
          col_r   <= col_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_r <= out_nxt;
  end

  a_ctag_needs_tend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.token_end |-> !out_r.closing_tag)
    else $error("closing_tag set without token_end");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last |=> lex_r == ST_TEXT && line_r == '0 && col_r == '0
                                 && !close_r && !cact_r)
    else $error("stream state not cleared after last byte");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted byte produced no result");

  a_newline_col: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_nl |=> col_r == '0)
    else $error("column not cleared after newline");

  a_no_tend_state: assert property (@(posedge clk) disable iff (!rst_n)
    lex_r != ST_TEND)
    else $error("token end state held in lexer register");

endmodule

// ===== bench/markup_byte_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_byte_tokenizer_tb: self-checking bench for the markup byte tokenizer
// Feeds hand-written markup, a back-to-back burst of newlines and text, and
// random documents made of tags, comments, declarations, text and noise.
// Both handshake sides stall at random. Every result is compared field by
// field against a cycle-free model of the lexer.
// ----------------------------------------------------------------------------
module markup_byte_tokenizer_tb;
  import mbt_pkg::*;

  localparam int unsigned POS_W       = POSITION_WIDTH_DEF;
  localparam int unsigned FULL_RUN    = 24;
  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned MAX_REPORTS = 50;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  markup_byte_tokenizer #(.POSITION_WIDTH(POS_W)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lexer model state
  lex_state_t       lex_now;
  logic             tag_closing;
  logic             in_comment;
  logic [POS_W-1:0] line_cnt;
  logic [POS_W-1:0] col_cnt;

  out_t        predicted_bytes [$];
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned token_ends = 0;
  int unsigned streams_ended = 0;
  int unsigned cycle_cnt = 0;

  function automatic void reset_tokenizer_model();
    lex_now     = ST_TEXT;
    tag_closing = 1'b0;
    in_comment  = 1'b0;
    line_cnt    = '0;
    col_cnt     = '0;
  endfunction

  function automatic out_t tokenize_byte(in_t req);
    lex_state_t cur;
    lex_state_t nxt;
    logic [7:0] c;
    out_t       res;
    c   = req.byte_in;
    cur = lex_now;
    res = '0;

    if (c == CHAR_NL) begin
      if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
      col_cnt = '0;
    end else if (col_cnt != '1) begin
      col_cnt = col_cnt + 1'b1;
    end

    if (cur == ST_SLASH) tag_closing = 1'b1;
    if (cur == ST_TAG_OPEN) tag_closing = 1'b0;

    case (cur)
      ST_LT:               nxt = (c == CHAR_BANG) ? ST_BANG :
                                 (c == CHAR_SLASH) ? ST_SLASH : ST_TAG_OPEN;
      ST_TAG, ST_TAG_OPEN: nxt = (c == CHAR_GT) ? ST_TEND :
                                 (c == CHAR_LT) ? ST_LT : ST_TAG;
      ST_SLASH:            nxt = ST_TAG;
      ST_TEND:             nxt = ST_TEXT;
      ST_BANG:             nxt = (c == CHAR_DASH) ? ST_DASH1 : ST_TAG;
      ST_DASH2:            nxt = (c == CHAR_DASH) ? ST_CEND : ST_COMMENT;
      ST_CEND:             nxt = (c == CHAR_GT) ? ST_TEND : ST_COMMENT;
      ST_DASH1:            nxt = (c == CHAR_DASH) ? ST_COMMENT : ST_TAG;
      ST_COMMENT:          nxt = (c == CHAR_DASH) ? ST_DASH2 : ST_COMMENT;
      default:             nxt = (c == CHAR_LT) ? ST_LT : ST_TEXT;
    endcase

    if (cur == ST_COMMENT) in_comment = (nxt == ST_COMMENT);

    if (nxt == ST_TAG || nxt == ST_TAG_OPEN) res.role = ROLE_TAG;
    else if (nxt == ST_TEXT && cur == ST_TEXT) res.role = ROLE_TEXT;
    else if (in_comment) res.role = ROLE_COMMENT;
    else res.role = ROLE_NONE;

    // Skip the token-end state: the closing '>' lands straight in text.
    if (nxt == ST_TEND) begin
      res.token_end   = 1'b1;
      res.closing_tag = tag_closing;
      nxt             = ST_TEXT;
    end
    lex_now = nxt;

    if (req.last) begin
      res.token_end   = 1'b1;
      res.closing_tag = tag_closing;
    end
    res.byte_out      = c;
    res.line_number   = POS_OUT_W'(line_cnt);
    res.column_number = POS_OUT_W'(col_cnt);

    if (req.last) reset_tokenizer_model();
    return res;
  endfunction

  // Random byte that is neither '<' nor '>', with frequent newlines.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) return CHAR_NL;
    c = 8'($urandom_range(0, 255));
    while (c == CHAR_LT || c == CHAR_GT) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic send_byte(logic [7:0] b, logic lst);
    int unsigned gap;
    in_t         req;
    out_t        pred;
    req.byte_in = b;
    req.last    = lst;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = tokenize_byte(req);
    predicted_bytes = {predicted_bytes, pred};
    bytes_sent++;
    if (lst) streams_ended++;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  initial begin : result_checker
    int unsigned stall;
    out_t        want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (out_data.token_end === 1'b1) token_ends++;
      if (predicted_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no request pending, expected none, actual byte %0d",
                   $time, out_data.byte_out);
      end else begin
        want = predicted_bytes.pop_front();
        check_field("byte_out", 16'(want.byte_out), 16'(out_data.byte_out));
        check_field("role", 16'(want.role), 16'(out_data.role));
        check_field("token_end", 16'(want.token_end), 16'(out_data.token_end));
        check_field("closing_tag", 16'(want.closing_tag), 16'(out_data.closing_tag));
        check_field("line_number", want.line_number, out_data.line_number);
        check_field("column_number", want.column_number, out_data.column_number);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, predicted_bytes.size());
      $display("markup_byte_tokenizer_tb NOT OK");
      $finish;
    end
  end

  // Tags, a closing tag, declaration, comment, restarted tag, byte extremes.
  task automatic test_directed();
    logic [7:0] doc [27];
    doc = '{8'h00, CHAR_LT, "p", CHAR_GT,
            CHAR_LT, CHAR_SLASH, "q", CHAR_GT,
            CHAR_LT, CHAR_BANG, "d", CHAR_GT,
            CHAR_LT, CHAR_BANG, CHAR_DASH, CHAR_DASH, "c", CHAR_DASH, CHAR_DASH, CHAR_GT,
            CHAR_LT, "a", CHAR_LT, "b", CHAR_GT,
            CHAR_NL, 8'hFF};
    for (int i = 0; i < 27; i++) send_byte(doc[i], i == 26);
  endtask

  // Back-to-back requests with the receiver always ready.
  task automatic test_full_rate();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (FULL_RUN) send_byte(CHAR_NL, 1'b0);
    repeat (FULL_RUN) send_byte("a", 1'b0);
    send_byte("a", 1'b1);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_documents(int unsigned target);
    logic [7:0]  frag [$];
    logic [7:0]  marks [6];
    int unsigned sent;
    int unsigned n;
    bit          end_here;
    marks = '{CHAR_LT, CHAR_GT, CHAR_BANG, CHAR_SLASH, CHAR_DASH, "x"};
    sent  = 0;
    while (sent < target) begin
      frag.delete();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      n = $urandom_range(1, 6);
      case ($urandom_range(0, 7))
        0, 1: repeat (n) frag = {frag, plain_char()};
        2: begin
          frag = {frag, CHAR_LT};
          repeat (n) frag = {frag, plain_char()};
          frag = {frag, CHAR_GT};
        end
        3: begin
          frag = {frag, CHAR_LT, CHAR_SLASH};
          repeat (n) frag = {frag, plain_char()};
          frag = {frag, CHAR_GT};
        end
        4: begin
          frag = {frag, CHAR_LT, CHAR_BANG, CHAR_DASH, CHAR_DASH};
          repeat (n) frag = {frag, (($urandom_range(0, 4) == 0) ? CHAR_DASH : plain_char())};
          frag = {frag, CHAR_DASH, CHAR_DASH, CHAR_GT};
        end
        5: begin
          frag = {frag, CHAR_LT, CHAR_BANG};
          repeat (n) frag = {frag, plain_char()};
          frag = {frag, CHAR_GT};
        end
        // broken markup: loose mix of the special characters
        6: repeat (n + 2) frag = {frag, marks[$urandom_range(0, 5)]};
        default: repeat (n) frag = {frag, 8'($urandom_range(0, 255))};
      endcase
      end_here = ($urandom_range(0, 15) == 0);
      foreach (frag[k]) send_byte(frag[k], end_here && (k == frag.size() - 1));
      sent += frag.size();
    end
  endtask

  initial begin
    reset_tokenizer_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_rate();
    test_random_documents(680);
    in_valid <= 1'b0;
    while (predicted_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d bytes in %0d streams, %0d results checked, %0d token ends",
             bytes_sent, streams_ended, results_seen, token_ends);
    $display("directed markup, a full-rate burst and random documents, %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("markup_byte_tokenizer_tb OK");
    end else begin
      $display("markup_byte_tokenizer_tb NOT OK");
    end
    $finish;
  end

endmodule
